/* design/asn1sp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package asn1sp_pkg;

  // Tags and length-octet masks
  localparam logic [7:0] TAG_SEQ        = 8'h30;
  localparam logic [7:0] TAG_INT        = 8'h02;
  localparam logic [7:0] LEN_LONG_MASK  = 8'h80;
  localparam logic [7:0] LEN_VALUE_MASK = 8'h7F;

  // Widest long-form length accepted, in length octets (at most 8)
  localparam int unsigned MAX_LEN_BYTES = 4;

  localparam int DEPTH_W  = 4;
  localparam int LEVEL_W  = 3;
  localparam int LENCNT_W = 4;

  // Event kinds
  localparam logic [2:0] EV_BEGIN = 3'd0;
  localparam logic [2:0] EV_INT   = 3'd1;
  localparam logic [2:0] EV_END   = 3'd2;
  localparam logic [2:0] EV_ERR   = 3'd3;
  localparam logic [2:0] EV_EMPTY = 3'd4;

  // Error codes
  localparam logic [1:0] ERR_TAG   = 2'd0;
  localparam logic [1:0] ERR_FIT   = 2'd1;
  localparam logic [1:0] ERR_WIDE  = 2'd2;
  localparam logic [1:0] ERR_TRUNC = 2'd3;

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_TAG,
    PH_LEN,
    PH_LONGLEN,
    PH_CONTENT,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    MD_STEP,
    MD_CLOSE,
    MD_TRUNC
  } mode_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [15:0] buffer_bytes;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [2:0]  nesting_level;
    logic [31:0] sequence_length;
    logic [7:0]  value_byte;
    logic        integer_last;
    logic [1:0]  error_code;
    logic        last_result;
  } out_item_t;

  typedef struct packed {
    logic        clear;
    logic        push;
    logic        pop;
    logic [31:0] push_val;
  } stk_cmd_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic               full;
    logic [31:0]        top;
    logic [31:0]        next;
  } stk_stat_t;

endpackage

`default_nettype wire

/* design/asn1_sequence_integer_parser.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Dir | Handshake          | Request
// ---------+-----+--------------------+--------------------------------------
// in_      | in  | in_valid/in_stall  | one byte of a DER buffer (in_item_t)
// out_     | out | out_valid/out_stall| one parse event (out_item_t)
//
// A byte that causes at most one event is finished in MD_STEP; the engine
// then takes a new byte every cycle unless out_ stalls. Sequence end events
// come from MD_CLOSE, which pops one stack entry per cycle unless out_
// stalls; MD_TRUNC sends a truncation error that follows another event.
// Reset is synchronous and active low; it clears control state and the
// stack depth. A stall on out_ holds the result register and, through the
// engine, the input register; a byte stays there until all its events left.
module asn1_sequence_integer_parser #(
  parameter int MAX_DEPTH = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  asn1sp_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output asn1sp_pkg::out_item_t out_data
);
  import asn1sp_pkg::*;

  // Input register
  logic      hold_valid_r;
  in_item_t  hold_r;

  // Result register
  logic      out_valid_r;
  out_item_t out_r;

  // Parse state
  mode_t               mode_r, mode_nxt;
  phase_t              phase_r;
  logic [31:0]         pos_r;
  logic [31:0]         acc_r;
  logic [LENCNT_W-1:0] lenleft_r;
  logic [31:0]         cont_r;
  logic                is_seq_r;

  stk_cmd_t  stk_cmd;
  stk_stat_t stk;

  logic              slot_free;
  logic              go;
  logic              item_done;
  logic              reset_all;

  logic [7:0]        b;
  logic [6:0]        n_len;
  logic [31:0]       pos_inc;
  logic [31:0]       buf32;
  logic [31:0]       acc_sat;
  logic [LENCNT_W-1:0] ll_dec;
  logic [31:0]       ld_len;
  logic              fit_bad;
  logic [31:0]       end_val;
  logic              int_close;
  phase_t            settle_phase;

  // Step results
  phase_t              s_phase;
  logic [31:0]         s_acc;
  logic [LENCNT_W-1:0] s_lenleft;
  logic [31:0]         s_cont;
  logic                s_is_seq;
  logic                s_ev_valid;
  out_item_t           s_ev;
  logic                s_push;
  logic                s_close;
  logic                ld;

  // Close loop and emit
  logic [DEPTH_W-1:0] dm1;
  logic               more_close;
  phase_t             c_phase;
  logic               trunc_step;
  logic               trunc_close;
  out_item_t          trunc_ev;
  out_item_t          end_ev;
  logic               emit_valid;
  out_item_t          emit_data;

  asn1sp_end_stack #(
    .MAX_DEPTH(MAX_DEPTH)
  ) u_stack (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (stk_cmd),
    .stat (stk)
  );

  // ---------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------
  assign slot_free = !out_valid_r || !out_stall;
  assign go        = hold_valid_r && slot_free;
  assign in_stall  = hold_valid_r && !(go && item_done);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      hold_valid_r <= 1'b1;
    end else if (go && item_done) begin
      hold_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_r <= in_data;
    end
  end

  // ---------------------------------------------------------------------
  // Shared datapath for one byte
  // ---------------------------------------------------------------------
  assign b       = hold_r.data_byte;
  assign n_len   = b[6:0] & LEN_VALUE_MASK[6:0];
  assign pos_inc = (pos_r == '1) ? pos_r : pos_r + 32'd1;
  assign buf32   = {16'd0, hold_r.buffer_bytes};
  // Saturate a long-form length that overflows 32 bits
  assign acc_sat = (acc_r > 32'h00FF_FFFF) ? '1 : {acc_r[23:0], b};
  assign ll_dec  = lenleft_r - LENCNT_W'(1);
  assign ld_len  = (phase_r == PH_LONGLEN) ? acc_sat :
                   ((b & LEN_LONG_MASK) != '0) ? 32'd0 : {25'd0, n_len};
  assign fit_bad = (pos_inc > buf32) || (ld_len > (buf32 - pos_inc));
  assign end_val = pos_inc + ld_len;
  // An element inside the current sequence ended: does the sequence too?
  assign int_close    = (stk.depth != '0) && (stk.top <= pos_inc);
  assign settle_phase = (stk.depth != '0) ? PH_TAG : PH_DONE;

  always_comb begin
    s_phase    = phase_r;
    s_acc      = acc_r;
    s_lenleft  = lenleft_r;
    s_cont     = cont_r;
    s_is_seq   = is_seq_r;
    s_ev_valid = 1'b0;
    s_ev       = '0;
    s_push     = 1'b0;
    s_close    = 1'b0;
    ld         = 1'b0;

    unique case (phase_r)
      PH_FIRST: begin
        if (b == TAG_SEQ) begin
          s_is_seq = 1'b1;
          s_phase  = PH_LEN;
        end else begin
          s_ev_valid       = 1'b1;
          s_ev.event_kind  = EV_ERR;
          s_ev.error_code  = ERR_TAG;
          s_phase          = PH_DONE;
        end
      end
      PH_TAG: begin
        if (b == TAG_SEQ && !stk.full) begin
          s_is_seq = 1'b1;
          s_phase  = PH_LEN;
        end else if (b == TAG_INT) begin
          s_is_seq = 1'b0;
          s_phase  = PH_LEN;
        end else begin
          s_ev_valid       = 1'b1;
          s_ev.event_kind  = EV_ERR;
          s_ev.error_code  = ERR_TAG;
          s_phase          = PH_DONE;
        end
      end
      PH_LEN: begin
        if ((b & LEN_LONG_MASK) != '0) begin
          if (n_len > 7'(MAX_LEN_BYTES)) begin
            s_ev_valid       = 1'b1;
            s_ev.event_kind  = EV_ERR;
            s_ev.error_code  = ERR_WIDE;
            s_phase          = PH_DONE;
          end else if (n_len == '0) begin
            s_acc = '0;
            ld    = 1'b1;
          end else begin
            s_acc     = '0;
            s_lenleft = n_len[LENCNT_W-1:0];
            s_phase   = PH_LONGLEN;
          end
        end else begin
          s_acc = ld_len;
          ld    = 1'b1;
        end
      end
      PH_LONGLEN: begin
        s_acc     = acc_sat;
        s_lenleft = ll_dec;
        if (ll_dec == '0) begin
          ld = 1'b1;
        end
      end
      PH_CONTENT: begin
        s_cont            = cont_r - 32'd1;
        s_ev_valid        = 1'b1;
        s_ev.event_kind   = EV_INT;
        s_ev.value_byte   = b;
        s_ev.integer_last = (cont_r == 32'd1);
        if (cont_r == 32'd1) begin
          if (int_close) begin
            s_close = 1'b1;
          end else begin
            s_phase = settle_phase;
          end
        end
      end
      PH_DONE: begin
        s_phase = PH_DONE;
      end
      default: begin
        s_phase = PH_DONE;
      end
    endcase

    // Declared length is complete: check it and open the element
    if (ld) begin
      if (fit_bad) begin
        s_ev_valid      = 1'b1;
        s_ev            = '0;
        s_ev.event_kind = EV_ERR;
        s_ev.error_code = ERR_FIT;
        s_phase         = PH_DONE;
      end else if (is_seq_r) begin
        if (stk.full) begin
          s_ev_valid      = 1'b1;
          s_ev            = '0;
          s_ev.event_kind = EV_ERR;
          s_ev.error_code = ERR_TAG;
          s_phase         = PH_DONE;
        end else begin
          s_ev_valid           = 1'b1;
          s_ev                 = '0;
          s_ev.event_kind      = EV_BEGIN;
          s_ev.nesting_level   = stk.depth[LEVEL_W-1:0];
          s_ev.sequence_length = ld_len;
          s_push               = 1'b1;
          // An empty sequence closes on the byte that opened it
          if (ld_len == '0) begin
            s_close = 1'b1;
          end else begin
            s_phase = PH_TAG;
          end
        end
      end else if (ld_len == '0) begin
        s_ev_valid      = 1'b1;
        s_ev            = '0;
        s_ev.event_kind = EV_EMPTY;
        if (int_close) begin
          s_close = 1'b1;
        end else begin
          s_phase = settle_phase;
        end
      end else begin
        s_cont  = ld_len;
        s_phase = PH_CONTENT;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Close loop helpers
  // ---------------------------------------------------------------------
  assign dm1         = stk.depth - DEPTH_W'(1);
  assign more_close  = (stk.depth >= DEPTH_W'(2)) && (stk.next <= pos_r);
  assign c_phase     = (dm1 != '0) ? PH_TAG : PH_DONE;
  assign trunc_step  = hold_r.last_byte && (s_phase != PH_DONE);
  assign trunc_close = hold_r.last_byte && (c_phase != PH_DONE);

  always_comb begin
    trunc_ev             = '0;
    trunc_ev.event_kind  = EV_ERR;
    trunc_ev.error_code  = ERR_TRUNC;
    trunc_ev.last_result = 1'b1;
    end_ev               = '0;
    end_ev.event_kind    = EV_END;
    end_ev.nesting_level = dm1[LEVEL_W-1:0];
  end

  // Next mode
  always_comb begin
    mode_nxt = mode_r;
    unique case (mode_r)
      MD_STEP: begin
        if (s_close) begin
          mode_nxt = MD_CLOSE;
        end else if (trunc_step && s_ev_valid) begin
          mode_nxt = MD_TRUNC;
        end
      end
      MD_CLOSE: begin
        if (!more_close) begin
          mode_nxt = trunc_close ? MD_TRUNC : MD_STEP;
        end
      end
      MD_TRUNC: begin
        mode_nxt = MD_STEP;
      end
      default: begin
        mode_nxt = MD_STEP;
      end
    endcase
  end

  // Events and completion for the current mode
  always_comb begin
    emit_valid = 1'b0;
    emit_data  = '0;
    item_done  = 1'b0;
    unique case (mode_r)
      MD_STEP: begin
        if (s_close) begin
          emit_valid = s_ev_valid;
          emit_data  = s_ev;
        end else if (trunc_step) begin
          if (s_ev_valid) begin
            emit_valid = 1'b1;
            emit_data  = s_ev;
          end else begin
            emit_valid = 1'b1;
            emit_data  = trunc_ev;
            item_done  = 1'b1;
          end
        end else begin
          emit_valid            = s_ev_valid;
          emit_data             = s_ev;
          emit_data.last_result = 1'b1;
          item_done             = 1'b1;
        end
      end
      MD_CLOSE: begin
        emit_valid = 1'b1;
        emit_data  = end_ev;
        if (!more_close && !trunc_close) begin
          emit_data.last_result = 1'b1;
          item_done             = 1'b1;
        end
      end
      MD_TRUNC: begin
        emit_valid = 1'b1;
        emit_data  = trunc_ev;
        item_done  = 1'b1;
      end
      default: begin
        item_done = 1'b1;
      end
    endcase
  end

  // Buffer end returns the parser to its reset state
  assign reset_all = go && item_done && hold_r.last_byte;

  always_comb begin
    stk_cmd          = '0;
    stk_cmd.clear    = reset_all;
    stk_cmd.push_val = end_val;
    if (go && mode_r == MD_STEP) begin
      stk_cmd.push = s_push;
    end
    if (go && mode_r == MD_CLOSE) begin
      stk_cmd.pop = 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // State registers
  // ---------------------------------------------------------------------
  // A finished byte always moves the mode back to MD_STEP
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MD_STEP;
      phase_r   <= PH_FIRST;
      pos_r     <= '0;
      acc_r     <= '0;
      lenleft_r <= '0;
      cont_r    <= '0;
      is_seq_r  <= 1'b0;
    end else if (go) begin
      mode_r <= mode_nxt;
      if (reset_all) begin
        phase_r   <= PH_FIRST;
        pos_r     <= '0;
        acc_r     <= '0;
        lenleft_r <= '0;
        cont_r    <= '0;
        is_seq_r  <= 1'b0;
      end else if (mode_r == MD_STEP) begin
        phase_r   <= s_phase;
        pos_r     <= pos_inc;
        acc_r     <= s_acc;
        lenleft_r <= s_lenleft;
        cont_r    <= s_cont;
        is_seq_r  <= s_is_seq;
      end else if (mode_r == MD_CLOSE && !more_close) begin
        phase_r <= c_phase;
      end
    end
  end

  // Result register: advance when empty or taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (slot_free) begin
      out_valid_r <= go && emit_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && go && emit_valid) begin
      out_r <= emit_data;
    end
  end

endmodule

`default_nettype wire

/* design/asn1sp_end_stack.sv */
`timescale 1ns / 1ps
`default_nettype none

// Stack of sequence end offsets. The innermost entry lives in its own
// register; the entry below it is read from the array at one address.
module asn1sp_end_stack #(
  parameter int MAX_DEPTH = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  asn1sp_pkg::stk_cmd_t  cmd,
  output asn1sp_pkg::stk_stat_t stat
);
  import asn1sp_pkg::*;

  localparam int LIMIT = (MAX_DEPTH < 8) ? MAX_DEPTH : 8;
  localparam int SLOTS = (LIMIT > 1) ? LIMIT - 1 : 1;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [DEPTH_W-1:0] depth_r;
  logic [31:0]        top_r;
  logic [31:0]        below_r [SLOTS];
  logic [DEPTH_W-1:0] dm1;
  logic [DEPTH_W-1:0] dm2;
  logic [IDX_W-1:0]   wr_idx;
  logic [IDX_W-1:0]   rd_idx;
  logic               has_below;

  assign dm1       = depth_r - DEPTH_W'(1);
  assign dm2       = depth_r - DEPTH_W'(2);
  assign wr_idx    = dm1[IDX_W-1:0];
  assign rd_idx    = dm2[IDX_W-1:0];
  assign has_below = (depth_r >= DEPTH_W'(2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else if (cmd.clear) begin
      depth_r <= '0;
    end else if (cmd.push) begin
      depth_r <= depth_r + DEPTH_W'(1);
    end else if (cmd.pop) begin
      depth_r <= dm1;
    end
  end

  // Push: old top moves down. Pop: entry below moves up.
  always_ff @(posedge clk) begin
    if (cmd.push && !cmd.clear) begin
      top_r <= cmd.push_val;
      if (depth_r != '0) begin
        below_r[wr_idx] <= top_r;
      end
    end else if (cmd.pop && has_below) begin
      top_r <= below_r[rd_idx];
    end
  end

  always_comb begin
    stat.depth = depth_r;
    stat.full  = (depth_r >= DEPTH_W'(LIMIT));
    stat.top   = top_r;
    stat.next  = has_below ? below_r[rd_idx] : '0;
  end

endmodule

`default_nettype wire

/* design/asn1sp_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module asn1sp_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_stall,
  input asn1sp_pkg::out_item_t out_data
);
  import asn1sp_pkg::*;

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.event_kind == EV_ERR |-> out_data.last_result)
    else $error("error event not the last of its byte");

  a_int_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.event_kind != EV_INT |->
      !out_data.integer_last && out_data.value_byte == 8'd0)
    else $error("integer fields set on another event");

  a_len_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.event_kind != EV_BEGIN |->
      out_data.sequence_length == 32'd0)
    else $error("sequence length set on another event");

endmodule

bind asn1_sequence_integer_parser asn1sp_checker u_asn1sp_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps

// Byte-serial DER parser check: well-formed SEQUENCE/INTEGER trees with
// random content, plus cut, squeezed, corrupted and noise buffers, all scored
// against an in-bench parse of every accepted byte.
module testbench;
  import asn1sp_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int STACK_LIMIT = 8;
  localparam int MAX_EVENTS = 9;
  localparam int RANDOM_BYTES = 335;
  localparam int SETTLE_CYCLES = 40;
  localparam int unsigned RUN_LIMIT_NS = 6_000_000;

  typedef logic [7:0] octets_t[$];

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;

  asn1_sequence_integer_parser #(
    .MAX_DEPTH(STACK_LIMIT)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Parser state mirrored in the bench
  logic [31:0] open_ends [0:STACK_LIMIT-1];
  logic [3:0] open_count;
  logic [31:0] bytes_seen;
  phase_t parse_state;
  logic [31:0] length_value;
  logic [6:0] length_octets_left;
  logic [31:0] content_left;
  logic header_is_seq;

  out_item_t byte_events[$];
  out_item_t awaited_events[$];

  bit quiet_link = 1'b0;
  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;
  int unsigned buffers_sent = 0;
  int unsigned events_checked = 0;
  int unsigned peak_events = 0;
  int unsigned kind_tally [0:7];

  task automatic report_mismatch(input string what);
    if (mismatches < 40)
      $display("MISMATCH at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  function automatic void clear_parser();
    open_count = '0;
    bytes_seen = '0;
    parse_state = PH_FIRST;
    length_value = '0;
    length_octets_left = '0;
    content_left = '0;
    header_is_seq = 1'b0;
  endfunction

  function automatic void note_event(input logic [2:0] kind, input logic [2:0] level,
                                     input logic [31:0] len, input logic [7:0] val,
                                     input logic ilast, input logic [1:0] code);
    out_item_t ev;
    if (byte_events.size() >= MAX_EVENTS) return;
    ev.event_kind = kind;
    ev.nesting_level = level;
    ev.sequence_length = len;
    ev.value_byte = val;
    ev.integer_last = ilast;
    ev.error_code = code;
    ev.last_result = 1'b0;
    byte_events.push_back(ev);
  endfunction

  function automatic void stop_parse(input logic [1:0] code);
    note_event(EV_ERR, '0, '0, '0, 1'b0, code);
    parse_state = PH_DONE;
  endfunction

  // Pop every sequence whose end offset has been reached, innermost first
  function automatic void pop_closed_sequences();
    while (open_count != 0 && open_ends[3'(open_count - 4'd1)] <= bytes_seen) begin
      open_count = open_count - 4'd1;
      note_event(EV_END, open_count[2:0], '0, '0, 1'b0, '0);
    end
    parse_state = (open_count != 0) ? PH_TAG : PH_DONE;
  endfunction

  function automatic void header_complete(input logic [31:0] limit);
    logic [31:0] pos;
    logic [31:0] len;
    pos = bytes_seen;
    len = length_value;
    if (pos > limit || len > limit - pos) begin
      stop_parse(ERR_FIT);
      return;
    end
    if (header_is_seq) begin
      if (open_count >= STACK_LIMIT) begin
        stop_parse(ERR_TAG);
        return;
      end
      note_event(EV_BEGIN, open_count[2:0], len, '0, 1'b0, '0);
      open_ends[open_count[2:0]] = pos + len;
      open_count = open_count + 4'd1;
      if (len == 0) pop_closed_sequences();
      else parse_state = PH_TAG;
    end else if (len == 0) begin
      note_event(EV_EMPTY, '0, '0, '0, 1'b0, '0);
      pop_closed_sequences();
    end else begin
      content_left = len;
      parse_state = PH_CONTENT;
    end
  endfunction

  // Advance the mirrored parser by one byte and queue the events it causes
  function automatic void derive_events(input in_item_t item);
    logic [7:0] b;
    logic [31:0] limit;
    logic [6:0] n;
    logic err_seen;
    out_item_t tail;
    b = item.data_byte;
    limit = {16'd0, item.buffer_bytes};
    byte_events.delete();
    if (bytes_seen != '1) bytes_seen = bytes_seen + 32'd1;
    case (parse_state)
      PH_FIRST: begin
        if (b == TAG_SEQ) begin
          header_is_seq = 1'b1;
          parse_state = PH_LEN;
        end else begin
          stop_parse(ERR_TAG);
        end
      end
      PH_TAG: begin
        if (b == TAG_SEQ && open_count < STACK_LIMIT) begin
          header_is_seq = 1'b1;
          parse_state = PH_LEN;
        end else if (b == TAG_INT) begin
          header_is_seq = 1'b0;
          parse_state = PH_LEN;
        end else begin
          stop_parse(ERR_TAG);
        end
      end
      PH_LEN: begin
        if ((b & LEN_LONG_MASK) != 0) begin
          n = 7'(b & LEN_VALUE_MASK);
          if (n > MAX_LEN_BYTES) begin
            stop_parse(ERR_WIDE);
          end else if (n == 0) begin
            length_value = '0;
            header_complete(limit);
          end else begin
            length_value = '0;
            length_octets_left = n;
            parse_state = PH_LONGLEN;
          end
        end else begin
          length_value = {24'd0, b};
          header_complete(limit);
        end
      end
      PH_LONGLEN: begin
        // Saturate instead of shifting out high bits
        if (length_value > 32'h00FF_FFFF) length_value = '1;
        else length_value = {length_value[23:0], b};
        length_octets_left = length_octets_left - 7'd1;
        if (length_octets_left == 0) header_complete(limit);
      end
      PH_CONTENT: begin
        content_left = content_left - 32'd1;
        note_event(EV_INT, '0, '0, b, content_left == 0, '0);
        if (content_left == 0) pop_closed_sequences();
      end
      default: parse_state = PH_DONE;
    endcase
    if (item.last_byte) begin
      err_seen = byte_events.size() != 0 &&
                 byte_events[byte_events.size() - 1].event_kind == EV_ERR;
      if (parse_state != PH_DONE && !err_seen)
        note_event(EV_ERR, '0, '0, '0, 1'b0, ERR_TRUNC);
      clear_parser();
    end
    if (byte_events.size() != 0) begin
      tail = byte_events.pop_back();
      tail.last_result = 1'b1;
      byte_events.push_back(tail);
    end
    if (byte_events.size() > peak_events) peak_events = byte_events.size();
    foreach (byte_events[i]) awaited_events.push_back(byte_events[i]);
  endfunction

  task automatic check_event(input out_item_t got);
    out_item_t want;
    if (awaited_events.size() == 0) begin
      report_mismatch($sformatf("event kind %0d with nothing awaited", got.event_kind));
      return;
    end
    want = awaited_events.pop_front();
    events_checked++;
    kind_tally[want.event_kind]++;
    if (got.event_kind !== want.event_kind)
      report_mismatch($sformatf("event_kind %0d, want %0d", got.event_kind, want.event_kind));
    if (got.nesting_level !== want.nesting_level)
      report_mismatch($sformatf("nesting_level %0d, want %0d", got.nesting_level,
                                want.nesting_level));
    if (got.sequence_length !== want.sequence_length)
      report_mismatch($sformatf("sequence_length %0d, want %0d", got.sequence_length,
                                want.sequence_length));
    if (got.value_byte !== want.value_byte)
      report_mismatch($sformatf("value_byte %h, want %h", got.value_byte, want.value_byte));
    if (got.integer_last !== want.integer_last)
      report_mismatch($sformatf("integer_last %b, want %b", got.integer_last, want.integer_last));
    if (got.error_code !== want.error_code)
      report_mismatch($sformatf("error_code %0d, want %0d", got.error_code, want.error_code));
    if (got.last_result !== want.last_result)
      report_mismatch($sformatf("last_result %b, want %b", got.last_result, want.last_result));
  endtask

  // Hold a request until the parser takes it; predict at the accepting edge
  task automatic send_byte(input in_item_t item);
    int unsigned gap;
    gap = quiet_link ? 0 : (($urandom_range(0, 2) == 0) ? $urandom_range(0, 9) : 0);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall !== 1'b0);
    derive_events(item);
    bytes_sent++;
  endtask

  task automatic send_buffer(input octets_t frame, input logic [15:0] declared);
    in_item_t item;
    foreach (frame[i]) begin
      item.data_byte = frame[i];
      item.last_byte = (i == frame.size() - 1);
      item.buffer_bytes = declared;
      send_byte(item);
    end
    buffers_sent++;
  endtask

  // Drop valid and let every awaited event drain
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (awaited_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic octets_t length_octets(input int unsigned n);
    octets_t q;
    int unsigned pick;
    pick = $urandom_range(0, 5);
    if (pick == 0) begin
      q.push_back(LEN_LONG_MASK | 8'(MAX_LEN_BYTES));
      q.push_back(8'(n >> 24));
      q.push_back(8'(n >> 16));
      q.push_back(8'(n >> 8));
      q.push_back(8'(n));
    end else if (n == 0 && pick == 1) begin
      q.push_back(LEN_LONG_MASK);
    end else if (n < 128 && pick > 1) begin
      q.push_back(8'(n));
    end else if (n < 256) begin
      q.push_back(LEN_LONG_MASK | 8'd1);
      q.push_back(8'(n));
    end else begin
      q.push_back(LEN_LONG_MASK | 8'd2);
      q.push_back(8'(n >> 8));
      q.push_back(8'(n));
    end
    return q;
  endfunction

  function automatic octets_t wrap_element(input logic [7:0] tag, input octets_t body);
    octets_t q;
    octets_t len_q;
    q.push_back(tag);
    len_q = length_octets(body.size());
    foreach (len_q[i]) q.push_back(len_q[i]);
    foreach (body[i]) q.push_back(body[i]);
    return q;
  endfunction

  function automatic octets_t random_integer();
    octets_t body;
    body.delete();
    if ($urandom_range(0, 5) != 0) repeat ($urandom_range(1, 4)) body.push_back(8'($urandom));
    return wrap_element(TAG_INT, body);
  endfunction

  // One nested sequence per level keeps the size linear in depth; a late
  // integer is rare, so several sequences tend to close on one byte
  function automatic octets_t random_sequence(input int unsigned levels_below);
    octets_t body;
    octets_t part;
    body.delete();
    repeat ($urandom_range(0, 2)) begin
      part = random_integer();
      foreach (part[i]) body.push_back(part[i]);
    end
    if (levels_below != 0) begin
      part = random_sequence(levels_below - 1);
      foreach (part[i]) body.push_back(part[i]);
    end
    if ($urandom_range(0, 3) == 0) begin
      part = random_integer();
      foreach (part[i]) body.push_back(part[i]);
    end
    return wrap_element(TAG_SEQ, body);
  endfunction

  function automatic octets_t nested_tower(input int unsigned levels);
    octets_t q;
    octets_t body;
    body.push_back(8'($urandom));
    q = wrap_element(TAG_INT, body);
    repeat (levels) q = wrap_element(TAG_SEQ, q);
    return q;
  endfunction

  task automatic test_child_past_parent();
    octets_t f;
    // Inner sequence overruns its parent; both close on the last content byte
    f = {TAG_SEQ, 8'h03, TAG_SEQ, 8'h04, TAG_INT, 8'h02, 8'h00, 8'hFF};
    send_buffer(f, 16'd8);
  endtask

  task automatic test_empty_integer();
    octets_t f;
    f = {TAG_SEQ, 8'h02, TAG_INT, 8'h00};
    send_buffer(f, 16'd4);
  endtask

  task automatic test_buffer_end_cases();
    octets_t f;
    // Bare long-form marker means length zero; the byte after the close is silent
    f = {TAG_SEQ, LEN_LONG_MASK, 8'hA5};
    send_buffer(f, 16'd3);
    // Buffer ends inside an element header
    f = {TAG_SEQ, 8'h03, TAG_INT};
    send_buffer(f, 16'd5);
  endtask

  task automatic test_header_errors();
    octets_t f;
    f = {TAG_INT};
    send_buffer(f, 16'hFFFF);
    f = {TAG_SEQ, LEN_LONG_MASK | 8'(MAX_LEN_BYTES + 1)};
    send_buffer(f, 16'd2);
    f = {TAG_SEQ, LEN_LONG_MASK | 8'd2, 8'hFF, 8'hFF};
    send_buffer(f, 16'hFFFF);
  endtask

  task automatic test_random_buffers();
    octets_t frame;
    int unsigned kind;
    int unsigned cut;
    int unsigned stop_at;
    int unsigned round;
    logic [15:0] declared;
    stop_at = bytes_sent + RANDOM_BYTES;
    round = 0;
    while (bytes_sent < stop_at) begin
      quiet_link = ($urandom_range(0, 4) == 0);
      // Open with two towers so the full stack and the depth limit are always hit
      kind = (round < 2) ? 50 : $urandom_range(0, 99);
      frame = random_sequence(($urandom_range(0, 7) == 0) ? 7 : $urandom_range(0, 3));
      declared = 16'(frame.size());
      if (kind < 45) begin
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 3)) frame.push_back(8'($urandom));
        declared = 16'(frame.size());
      end else if (kind < 55) begin
        if (round == 0) frame = nested_tower(STACK_LIMIT);
        else if (round == 1) frame = nested_tower(STACK_LIMIT + 1);
        else frame = nested_tower(($urandom_range(0, 2) == 0) ? STACK_LIMIT + 1 : STACK_LIMIT);
        declared = 16'(frame.size());
      end else if (kind < 65) begin
        // Cut short but keep the declared size
        cut = $urandom_range(1, frame.size() - 1);
        while (frame.size() > cut) void'(frame.pop_back());
      end else if (kind < 73) begin
        declared = 16'($urandom_range(1, frame.size() - 1));
      end else if (kind < 87) begin
        frame[$urandom_range(0, frame.size() - 1)] = 8'($urandom);
      end else begin
        frame.delete();
        repeat ($urandom_range(1, 6)) frame.push_back(8'($urandom));
        if ($urandom_range(0, 1) == 0) frame[0] = TAG_SEQ;
        declared = 16'($urandom_range(1, 65535));
      end
      send_buffer(frame, declared);
      if ($urandom_range(0, 15) == 0) wait_for_results();
      round++;
    end
    quiet_link = 1'b0;
  endtask

  // Result side: stall at random, then take one event
  initial begin : result_monitor
    int unsigned hold;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      hold = quiet_link ? 0 : (($urandom_range(0, 2) == 0) ? $urandom_range(1, 9) : 0);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      check_event(out_data);
    end
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("Timeout with %0d events still awaited", awaited_events.size());
    $display("** asn1_sequence_integer_parser: FAILED **");
    $finish;
  end

  initial begin : stimulus
    foreach (kind_tally[i]) kind_tally[i] = 0;
    clear_parser();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_child_past_parent();
    test_empty_integer();
    test_buffer_end_cases();
    test_header_errors();
    wait_for_results();
    test_random_buffers();
    wait_for_results();

    if (awaited_events.size() != 0)
      report_mismatch($sformatf("%0d events never arrived", awaited_events.size()));
    $display("Covered %0d buffers in %0d bytes; %0d events: %0d begin, %0d integer, %0d end,",
             buffers_sent, bytes_sent, events_checked, kind_tally[EV_BEGIN],
             kind_tally[EV_INT], kind_tally[EV_END]);
    $display("  %0d error, %0d empty integer; most events from one byte: %0d; mismatches: %0d",
             kind_tally[EV_ERR], kind_tally[EV_EMPTY], peak_events, mismatches);
    if (mismatches == 0) begin
      $display("** asn1_sequence_integer_parser: PASSED **");
    end else begin
      $display("** asn1_sequence_integer_parser: FAILED **");
    end
    $finish;
  end

endmodule
